// ===== src/bsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bisection square root package
// Field widths, reset values and the command/status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int N_BITS     = 32;
    localparam int ROOT_BITS  = 25;
    localparam int TOL_BITS   = 16;
    localparam int STEP_BITS  = 7;
    localparam int STEP_LIMIT = 128;

    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd59;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a new operand and set the initial interval
        logic square;    // form the midpoint and register its square
        logic update;    // move one bound to the midpoint
        logic out_load;  // copy the midpoint and the flag to the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;       // difference is below the tolerance
        logic stall;     // interval one LSB wide, or square equals the operand
    } dp_status_t;

endpackage
`default_nettype wire

// ===== src/bsr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bisection square root datapath
// Holds the bounds, the midpoint, its registered square, the tolerance
// register and the result register.
// ----------------------------------------------------------------------------
module bsr_datapath #(
    parameter int FRACTION_BITS = 16,
    parameter int INTEGER_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bsr_pkg::dp_cmd_t             cmd,
    output bsr_pkg::dp_status_t               status,
    input  wire logic [bsr_pkg::N_BITS-1:0]   n_value,
    input  wire logic                         tol_we,
    input  wire logic [bsr_pkg::TOL_BITS-1:0] tol_data,
    output logic [bsr_pkg::ROOT_BITS-1:0]     root,
    output logic                              met_tolerance
);

    localparam int W       = INTEGER_BITS + FRACTION_BITS;
    localparam int SQ_BITS = 2 * W - FRACTION_BITS;
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << FRACTION_BITS;

    logic [W-1:0]                 n_reg, lo_reg, hi_reg, mid_reg;
    logic [W-1:0]                 n_next, lo_next, hi_next, mid_next;
    logic [2*W-1:0]               prod_reg, prod_next;
    logic [W:0]                   sum;
    logic [SQ_BITS-1:0]           sq, n_ext, diff;
    logic                         greater, less;
    logic [bsr_pkg::TOL_BITS-1:0] tol_reg;
    logic [bsr_pkg::ROOT_BITS-1:0] root_reg;
    logic                         met_reg;

    assign n_next    = W'(n_value);
    assign sum       = (W+1)'(lo_reg) + (W+1)'(hi_reg);
    assign mid_next  = sum[W:1];
    assign prod_next = (2*W)'(mid_next) * (2*W)'(mid_next);

    // Square scaled back to the operand's format, truncated.
    assign sq      = prod_reg[2*W-1:FRACTION_BITS];
    assign n_ext   = SQ_BITS'(n_reg);
    assign greater = sq > n_ext;
    assign less    = sq < n_ext;
    assign diff    = greater ? (sq - n_ext) : (n_ext - sq);

    assign status.hit   = diff < SQ_BITS'(tol_reg);
    assign status.stall = ((hi_reg - lo_reg) <= W'(1)) || (!greater && !less);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.load)
        begin
            if (n_next >= ONE)
            begin
                lo_next = ONE;
                hi_next = n_next;
            end
            else
            begin
                lo_next = n_next;
                hi_next = ONE;
            end
        end
        else if (cmd.update)
        begin
            if (less)
                lo_next = mid_reg;
            else
                hi_next = mid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= bsr_pkg::TOL_RESET;
        end
        else if (tol_we)
        begin
            tol_reg <= tol_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            lo_reg   <= '0;
            hi_reg   <= '0;
            mid_reg  <= '0;
            prod_reg <= '0;
            root_reg <= '0;
            met_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                n_reg <= n_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            if (cmd.square)
            begin
                mid_reg  <= mid_next;
                prod_reg <= prod_next;
            end
            if (cmd.out_load)
            begin
                root_reg <= bsr_pkg::ROOT_BITS'(mid_reg);
                met_reg  <= status.hit;
            end
        end
    end

    assign root          = root_reg;
    assign met_tolerance = met_reg;

endmodule
`default_nettype wire

// ===== src/bsr_control.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bisection square root controller
// Sequences load, square and check steps, counts steps and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module bsr_control (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output bsr_pkg::dp_cmd_t          cmd,
    input  wire bsr_pkg::dp_status_t  status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK
    } state_t;

    state_t                        state_reg, state_next;
    logic [bsr_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          done, slot_free;

    assign done      = status.hit || status.stall
                       || (step_reg == bsr_pkg::STEP_BITS'(bsr_pkg::STEP_LIMIT - 1));
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tready)
            m_tvalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // A finished search waits here while the result register is full.
                if (done)
                begin
                    if (slot_free)
                    begin
                        cmd.out_load  = 1'b1;
                        m_tvalid_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.update = 1'b1;
                    step_next  = step_reg + 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while a beat was pending");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SQUARE))
        else $error("accepted beat did not start a search");

    a_rise_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_CHECK))
        else $error("result raised outside of a check step");

    a_update_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !cmd.out_load && !done)
        else $error("bounds moved on a finished search");

endmodule
`default_nettype wire

// ===== src/bisection_square_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bisection square root
// Unsigned fixed-point square root found by bisecting the interval between
// the operand and one, one squaring per step.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                        Contents
//  s_*       in   s_tvalid s_tready s_tdata      n_value
//  m_*       out  m_tvalid m_tready m_tdata      root, met_tolerance (tuser)
//  cfg_*     in   cfg_valid cfg_ready cfg_data   tolerance
//
//  A search runs from the input beat through S bisection steps to the result, S
//  being the number of steps (at most about word width + 1, 33 for Q16.16).
//  Each step forms and squares the midpoint through the single multiplier in
//  ST_SQUARE, then compares and moves a bound in ST_CHECK.
//  Reset clears the controller and sets the tolerance to 59.
//  A new beat is taken while a finished result still waits on m_tready; a
//  second finished search holds until that result is taken.
// ----------------------------------------------------------------------------
module bisection_square_root #(
    parameter int FRACTION_BITS = 16,
    parameter int INTEGER_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] n_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [24:0] root, [31:25] zero
    output logic             m_tuser,   // [0] met_tolerance
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // [15:0] tolerance
);

    bsr_pkg::dp_cmd_t              cmd;
    bsr_pkg::dp_status_t           status;
    logic [bsr_pkg::ROOT_BITS-1:0] root;

    assign cfg_ready = 1'b1;

    bsr_control u_control (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bsr_datapath #(
        .FRACTION_BITS (FRACTION_BITS),
        .INTEGER_BITS  (INTEGER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .n_value       (s_tdata),
        .tol_we        (cfg_valid && cfg_ready),
        .tol_data      (cfg_data),
        .root          (root),
        .met_tolerance (m_tuser)
    );

    assign m_tdata = {{(32 - bsr_pkg::ROOT_BITS){1'b0}}, root};

endmodule
`default_nettype wire

// ===== tb/sv/bisection_square_root_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bisection square root testbench
// Drives Q16.16 operands into the stream input, collects roots and the
// met-tolerance flag from the stream output, and compares every beat with a
// bit-exact bisection computed here. A short table of hand-picked operands
// runs first, then phases of random operands under different tolerances,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module bisection_square_root_tb;

    localparam int FRACTION_BITS = 16;
    localparam int INTEGER_BITS  = 16;
    localparam int NUM_DIRECTED  = 24;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 148;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 100;

    typedef struct packed {
        logic [bsr_pkg::ROOT_BITS-1:0] root;
        logic                          met;
    } root_result_t;

    typedef struct packed {
        logic [bsr_pkg::TOL_BITS-1:0]  tol;
        logic [bsr_pkg::N_BITS-1:0]    n;
        logic                          typed;     // expected root and flag given below
        logic [bsr_pkg::ROOT_BITS-1:0] root;
        logic                          met;
    } directed_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [31:0] n_value
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // [24:0] root, [31:25] zero
    logic              m_tuser;   // [0] met_tolerance
    logic              cfg_valid;
    logic              cfg_ready;
    logic [15:0]       cfg_data;  // [15:0] tolerance

    // Copy of the tolerance register and the search registers.
    logic [bsr_pkg::TOL_BITS-1:0] tol_setting;
    logic [63:0]                  lo_bound;
    logic [63:0]                  hi_bound;
    logic [63:0]                  mid_val;

    root_result_t pending_roots[$];
    int           error_count;
    bit           source_gaps;
    bit           sink_gaps;
    bit           long_hold_req;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{16'd59,    32'h0001_0000, 1'b1, 25'd65536, 1'b1},
        '{16'd59,    32'h0000_0000, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h0000_0001, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h0000_FFFF, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h0001_0001, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h0002_0000, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h0004_0000, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h0009_0000, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h8000_0000, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h5555_5555, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'hAAAA_AAAA, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'hFFFF_FFFF, 1'b0, 25'd0,     1'b0},
        '{16'd59,    32'h7FFF_FFFF, 1'b0, 25'd0,     1'b0},
        '{16'd0,     32'h0001_0000, 1'b1, 25'd65536, 1'b0},
        '{16'd0,     32'h0004_0000, 1'b0, 25'd0,     1'b0},
        '{16'd0,     32'h0000_0000, 1'b0, 25'd0,     1'b0},
        '{16'd0,     32'hFFFF_FFFF, 1'b0, 25'd0,     1'b0},
        '{16'd0,     32'h0000_003B, 1'b0, 25'd0,     1'b0},
        '{16'd65535, 32'h0001_0000, 1'b1, 25'd65536, 1'b1},
        '{16'd65535, 32'h0000_0000, 1'b1, 25'd32768, 1'b1},
        '{16'd65535, 32'hFFFF_FFFF, 1'b0, 25'd0,     1'b0},
        '{16'd65535, 32'h0000_1234, 1'b0, 25'd0,     1'b0},
        '{16'd1,     32'h0019_0000, 1'b0, 25'd0,     1'b0},
        '{16'd1,     32'h1234_5678, 1'b0, 25'd0,     1'b0}
    };

    bisection_square_root #(
        .FRACTION_BITS (FRACTION_BITS),
        .INTEGER_BITS  (INTEGER_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Bit-exact bisection: the square is truncated to FRACTION_BITS and the
    // search ends on the tolerance, a one-LSB interval, an exact hit or the step limit.
    function automatic root_result_t sqrt_bisect(input logic [bsr_pkg::N_BITS-1:0] n);
        logic [63:0]  one_q;
        logic [63:0]  sq;
        logic [63:0]  diff;
        logic         greater;
        logic         less;
        root_result_t res;
        one_q = 64'd1 << FRACTION_BITS;
        if (64'(n) >= one_q)
        begin
            lo_bound = one_q;
            hi_bound = 64'(n);
        end
        else
        begin
            lo_bound = 64'(n);
            hi_bound = one_q;
        end
        res.met = 1'b0;
        for (int step = 0; step < bsr_pkg::STEP_LIMIT; step++)
        begin
            mid_val = (lo_bound + hi_bound) >> 1;
            sq      = (mid_val * mid_val) >> FRACTION_BITS;
            greater = sq > 64'(n);
            less    = sq < 64'(n);
            diff    = greater ? sq - 64'(n) : 64'(n) - sq;
            if (diff < 64'(tol_setting))
            begin
                res.met = 1'b1;
                break;
            end
            if (hi_bound - lo_bound <= 64'd1 || (!greater && !less))
                break;
            if (less)
                lo_bound = mid_val;
            else
                hi_bound = mid_val;
        end
        res.root = mid_val[bsr_pkg::ROOT_BITS-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [bsr_pkg::N_BITS-1:0] random_operand();
        logic [63:0] r;
        logic [63:0] sq;
        int          kind;
        kind = $urandom_range(0, 9);
        r    = 64'($urandom & 32'h00FF_FFFF);
        sq   = (r * r) >> FRACTION_BITS;
        case (kind)
            0, 1, 2: return $urandom;
            3:       return $urandom_range(0, 65535);
            4:       return $urandom >> $urandom_range(0, 31);
            5, 6:
            begin
                // Roots with cleared low bits give squares that are exact when at least eight low bits are clear.
                r  = r & ~((64'd1 << $urandom_range(0, 16)) - 64'd1);
                sq = (r * r) >> FRACTION_BITS;
                return sq[bsr_pkg::N_BITS-1:0];
            end
            7:
            begin
                if ($urandom_range(0, 1) == 0 && sq > 64'd70)
                    return sq[bsr_pkg::N_BITS-1:0] - $urandom_range(0, 70);
                if (sq < 64'hFFFF_FF00)
                    return sq[bsr_pkg::N_BITS-1:0] + $urandom_range(0, 70);
                return sq[bsr_pkg::N_BITS-1:0];
            end
            8:       return 32'h0001_0000 + $urandom_range(0, 200) - 32'd100;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return 32'h0000_0000;
                    1:       return 32'h0000_0001;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'hFFFF_FFFE;
                    4:       return 32'h0000_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
        endcase
    endfunction

    task automatic wait_all_roots();
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [bsr_pkg::TOL_BITS-1:0] value);
        wait_all_roots();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        tol_setting = value;
    endtask

    // Offers one operand beat; s_tvalid is lowered here only for a gap drawn before the beat.
    task automatic send_operand(input logic [bsr_pkg::N_BITS-1:0] n,
                                output root_result_t res);
        int gap;
        gap = source_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= n;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = sqrt_bisect(n);
        pending_roots.push_back(res);
    endtask

    // Output side: checks each beat and draws the stall pattern.
    initial
    begin
        int           gap_left;
        root_result_t want;
        gap_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_roots.size() == 0)
                begin
                    $error("unexpected result beat: root %0d, met_tolerance %0d",
                           m_tdata[bsr_pkg::ROOT_BITS-1:0], m_tuser);
                    error_count++;
                end
                else
                begin
                    want = pending_roots.pop_front();
                    if (m_tdata[bsr_pkg::ROOT_BITS-1:0] !== want.root)
                    begin
                        $error("root: expected %0d, got %0d",
                               want.root, m_tdata[bsr_pkg::ROOT_BITS-1:0]);
                        error_count++;
                    end
                    if (m_tuser !== want.met)
                    begin
                        $error("met_tolerance: expected %0d, got %0d", want.met, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[31:bsr_pkg::ROOT_BITS] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h",
                               m_tdata[31:bsr_pkg::ROOT_BITS]);
                        error_count++;
                    end
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                gap_left      = LONG_HOLD;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_gaps && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    initial
    begin
        root_result_t                 got;
        logic [bsr_pkg::TOL_BITS-1:0] next_tol;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        tol_setting   = bsr_pkg::TOL_RESET;
        lo_bound      = '0;
        hi_bound      = '0;
        mid_val       = '0;
        error_count   = 0;
        source_gaps   = 1'b1;
        sink_gaps     = 1'b1;
        long_hold_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (directed_rows[i].tol != tol_setting)
            begin
                s_tvalid <= 1'b0;
                write_tolerance(directed_rows[i].tol);
            end
            send_operand(directed_rows[i].n, got);
            if (directed_rows[i].typed &&
                (got.root !== directed_rows[i].root || got.met !== directed_rows[i].met))
            begin
                $error("table row %0d: expected root %0d met %0d, computed %0d %0d", i,
                       directed_rows[i].root, directed_rows[i].met, got.root, got.met);
                error_count++;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       next_tol = bsr_pkg::TOL_RESET;
                1:       next_tol = '0;
                2:       next_tol = '1;
                3:       next_tol = 16'd1;
                4:       next_tol = $urandom_range(2, 200);
                5:       next_tol = $urandom_range(0, 65535);
                6:       next_tol = $urandom_range(0, 16);
                7:       next_tol = bsr_pkg::TOL_RESET;
                default: next_tol = $urandom_range(0, 1000);
            endcase
            s_tvalid <= 1'b0;
            write_tolerance(next_tol);
            source_gaps = (phase != 2 && phase != 6);
            sink_gaps   = (phase != 2 && phase != 7);
            // The output stalls long enough for the block to fill and stop
            // taking input beats while operands keep coming.
            if (phase == 3)
                long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 5 && k == PHASE_ITEMS / 2)
                begin
                    s_tvalid <= 1'b0;
                    wait_all_roots();
                end
                send_operand(random_operand(), got);
            end
        end

        s_tvalid <= 1'b0;
        wait_all_roots();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
